### rtl/slpd_pkg.sv
package slpd_pkg;

    // Header length in bytes and derived widths
    localparam int LENGTH_BYTES = 8;
    localparam int LENGTH_W     = 8 * LENGTH_BYTES;
    localparam int HC_W         = $clog2(LENGTH_BYTES + 1);
    localparam int BIT_CNT_W    = 3;
    localparam int PCOUNT_W     = 32;
    localparam int CFG_W        = 32;
    localparam int CMP_W        = (LENGTH_W > CFG_W) ? LENGTH_W : CFG_W;

    // Config port
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_LENGTH = '0;
    localparam logic [CFG_W-1:0]     MAX_LENGTH_RST = 32'd65536;

    typedef enum logic [1:0] {
        STATUS_ACK      = 2'd0,
        STATUS_TOO_LONG = 2'd1,
        STATUS_HALTED   = 2'd2
    } status_t;

    // Byte assembled from the serial bits
    typedef struct packed {
        logic       byte_done;
        logic [7:0] data;
    } gather_t;

    // One result item
    typedef struct packed {
        status_t    status;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_message;
    } result_t;

endpackage

### rtl/slpd_bit_gather.sv
module slpd_bit_gather
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  bit_value,
    output slpd_pkg::gather_t     gather
);

    logic [7:0]                         bit_shift_reg;
    logic [7:0]                         bit_shift_next;
    logic [slpd_pkg::BIT_CNT_W-1:0]     bit_count_reg;
    logic [slpd_pkg::BIT_CNT_W-1:0]     bit_count_next;
    logic [7:0]                         assembled;

    // LSB first: new bit lands at the current count position
    assign assembled = bit_shift_reg | (8'(bit_value) << bit_count_reg);

    always_comb
    begin
        gather.data      = assembled;
        gather.byte_done = (bit_count_reg == '1);
    end

    always_comb
    begin
        bit_shift_next = bit_shift_reg;
        bit_count_next = bit_count_reg;
        if (advance)
        begin
            if (gather.byte_done)
            begin
                bit_shift_next = '0;
                bit_count_next = '0;
            end
            else
            begin
                bit_shift_next = assembled;
                bit_count_next = bit_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_shift_reg <= '0;
            bit_count_reg <= '0;
        end
        else
        begin
            bit_shift_reg <= bit_shift_next;
            bit_count_reg <= bit_count_next;
        end
    end

endmodule

### rtl/slpd_frame_ctrl.sv
module slpd_frame_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  slpd_pkg::gather_t             gather,
    input  logic [slpd_pkg::CFG_W-1:0]    max_length,
    output logic                          halted,
    output slpd_pkg::result_t             result
);

    logic [slpd_pkg::HC_W-1:0]      header_count_reg;
    logic [slpd_pkg::HC_W-1:0]      header_count_next;
    logic [slpd_pkg::LENGTH_W-1:0]  message_length_reg;
    logic [slpd_pkg::LENGTH_W-1:0]  message_length_next;
    logic [slpd_pkg::PCOUNT_W-1:0]  payload_count_reg;
    logic [slpd_pkg::PCOUNT_W-1:0]  payload_count_next;
    logic                           halted_reg;
    logic                           halted_next;

    logic [slpd_pkg::LENGTH_W-1:0]  length_ins;
    logic [slpd_pkg::PCOUNT_W-1:0]  payload_inc;
    logic                           in_header;
    logic                           too_long;
    logic                           is_last;

    assign halted = halted_reg;

    always_comb
    begin
        length_ins = message_length_reg;
        for (int i = 0; i < slpd_pkg::LENGTH_BYTES; i++)
        begin
            if (header_count_reg == slpd_pkg::HC_W'(i))
            begin
                length_ins[8*i +: 8] = gather.data;
            end
        end
    end

    assign in_header   = (header_count_reg < slpd_pkg::HC_W'(slpd_pkg::LENGTH_BYTES));
    assign too_long    = (slpd_pkg::CMP_W'(message_length_reg) >
                          slpd_pkg::CMP_W'(max_length));
    assign payload_inc = payload_count_reg + 1'b1;
    // A passing length fits in 32 bits and the count never overtakes it
    assign is_last     = (payload_inc == slpd_pkg::PCOUNT_W'(message_length_reg));

    always_comb
    begin
        header_count_next   = header_count_reg;
        message_length_next = message_length_reg;
        payload_count_next  = payload_count_reg;
        halted_next         = halted_reg;
        result              = '0;
        result.status       = slpd_pkg::STATUS_ACK;

        if (halted_reg)
        begin
            result.status = slpd_pkg::STATUS_HALTED;
        end
        else if (gather.byte_done)
        begin
            if (in_header)
            begin
                header_count_next   = header_count_reg + 1'b1;
                message_length_next = length_ins;
                if ((header_count_reg == slpd_pkg::HC_W'(slpd_pkg::LENGTH_BYTES - 1)) &&
                    (length_ins == '0))
                begin
                    result.empty_message = 1'b1;
                    header_count_next    = '0;
                    message_length_next  = '0;
                    payload_count_next   = '0;
                end
            end
            else if (too_long)
            begin
                result.status = slpd_pkg::STATUS_TOO_LONG;
                halted_next   = 1'b1;
            end
            else
            begin
                payload_count_next = payload_inc;
                result.byte_valid  = 1'b1;
                result.data_byte   = gather.data;
                if (is_last)
                begin
                    result.last_byte    = 1'b1;
                    header_count_next   = '0;
                    message_length_next = '0;
                    payload_count_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg   <= '0;
            message_length_reg <= '0;
            payload_count_reg  <= '0;
            halted_reg         <= 1'b0;
        end
        else if (accept)
        begin
            header_count_reg   <= header_count_next;
            message_length_reg <= message_length_next;
            payload_count_reg  <= payload_count_next;
            halted_reg         <= halted_next;
        end
    end

endmodule

### rtl/serial_length_prefixed_deframer_core.sv
// Serial length-prefixed deframer.
//
// Input channel (in_valid/in_ready, bit_value): one serial bit per transfer,
// least significant bit first. Every eight bits form a byte. The first eight
// bytes of a message are a little-endian length; each following byte is
// payload, and the byte that completes the length is flagged last_byte.
// A zero length ends the message at once (empty_message).
//
// Output channel (out_valid/out_ready): exactly one result transfer per input
// transfer, carrying status, byte_valid, data_byte, last_byte, empty_message.
// The result is registered and is valid the cycle after the input is taken.
// Throughput is one bit per cycle while out_ready is high, set by the single
// output register. When the receiver stalls, the result is held and in_ready
// drops until it is taken; in_ready is high whenever the output register is
// empty or is being drained in the same cycle.
//
// A payload byte of a message longer than max_length reports status 1 and
// halts the block; every later bit answers status 2 until reset.
// Reset (rst_n, async) clears all framing state, empties the output register
// and sets max_length to 65536. max_length is written over the APB port.
module serial_length_prefixed_deframer_core
(
    input  logic                             clk,
    input  logic                             rst_n,

    // APB config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [slpd_pkg::ADDR_W-1:0]      paddr,
    input  logic [slpd_pkg::CFG_W-1:0]       pwdata,
    output logic [slpd_pkg::CFG_W-1:0]       prdata,
    output logic                             pready,

    // Input bit stream
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             bit_value,

    // Result stream
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic                             byte_valid,
    output logic [7:0]                       data_byte,
    output logic                             last_byte,
    output logic                             empty_message
);

    logic [slpd_pkg::CFG_W-1:0]      max_length_reg;
    logic [slpd_pkg::CFG_W-1:0]      max_length_next;
    logic [slpd_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                            cfg_write;

    logic                            in_accept;
    logic                            halted;
    slpd_pkg::gather_t               gather;
    slpd_pkg::result_t               result;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    slpd_pkg::result_t               result_reg;

    // ------------------------------------------------------------------
    // Config register
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[slpd_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        max_length_next = max_length_reg;
        if (cfg_write && (reg_idx == slpd_pkg::REG_MAX_LENGTH))
        begin
            max_length_next = pwdata;
        end
    end

    assign prdata = (reg_idx == slpd_pkg::REG_MAX_LENGTH) ? max_length_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= slpd_pkg::MAX_LENGTH_RST;
        end
        else
        begin
            max_length_reg <= max_length_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: take a new bit whenever the result slot frees up
    // ------------------------------------------------------------------
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    slpd_bit_gather u_gather
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (in_accept && !halted),
        .bit_value (bit_value),
        .gather    (gather)
    );

    slpd_frame_ctrl u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .gather     (gather),
        .max_length (max_length_reg),
        .halted     (halted),
        .result     (result)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign byte_valid    = result_reg.byte_valid;
    assign data_byte     = result_reg.data_byte;
    assign last_byte     = result_reg.last_byte;
    assign empty_message = result_reg.empty_message;

endmodule

### tb/slpd_frame_checker.sv
`timescale 1ns / 1ps

module slpd_frame_checker
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slpd_pkg::ADDR_W-1:0]   paddr,
    input  logic [slpd_pkg::CFG_W-1:0]    pwdata,
    input  logic [slpd_pkg::CFG_W-1:0]    prdata,
    input  logic                          pready,

    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          bit_value,

    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [1:0]                    status,
    input  logic                          byte_valid,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    input  logic                          empty_message,

    output int                            fail_count,
    output int                            pending,
    output int                            bits_seen,
    output int                            bytes_seen,
    output int                            last_seen,
    output int                            empty_seen,
    output int                            too_long_seen,
    output int                            halted_seen
);

    import slpd_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_MAX_LENGTH  = {REG_MAX_LENGTH, 2'b00};
    localparam int                SHOWN_MISMATCHES = 10;

    // Deframer state as predicted
    logic [CFG_W-1:0]     max_len;
    logic [7:0]           shift_byte;
    logic [BIT_CNT_W-1:0] bit_idx;
    int unsigned          hdr_bytes;
    logic [LENGTH_W-1:0]  frame_len;
    logic [PCOUNT_W-1:0]  payload_seen;
    logic                 halted;

    result_t              expected_results[$];
    result_t              want;
    result_t              got;

    function automatic void restart_frame();
        hdr_bytes    = 0;
        frame_len    = '0;
        payload_seen = '0;
    endfunction

    // Advance the framing state by one serial bit, return the answer it earns
    function automatic result_t deframe_bit(input logic b);
        result_t    r;
        logic [7:0] full_byte;
        r = '0;
        if (halted)
        begin
            r.status = STATUS_HALTED;
            return r;
        end
        shift_byte = shift_byte | (8'(b) << bit_idx);
        if (bit_idx != 3'd7)
        begin
            bit_idx = bit_idx + 1'b1;
            return r;
        end
        full_byte  = shift_byte;
        shift_byte = '0;
        bit_idx    = '0;
        if (hdr_bytes < LENGTH_BYTES)
        begin
            frame_len = frame_len | (LENGTH_W'(full_byte) << (8 * hdr_bytes));
            hdr_bytes++;
            if (hdr_bytes == LENGTH_BYTES && frame_len == '0)
            begin
                r.empty_message = 1'b1;
                restart_frame();
            end
            return r;
        end
        // length checked against the register as it stands now
        if (frame_len > LENGTH_W'(max_len))
        begin
            r.status = STATUS_TOO_LONG;
            halted   = 1'b1;
            return r;
        end
        payload_seen   = payload_seen + 1'b1;
        r.byte_valid   = 1'b1;
        r.data_byte    = full_byte;
        if (LENGTH_W'(payload_seen) >= frame_len)
        begin
            r.last_byte = 1'b1;
            restart_frame();
        end
        return r;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("status %0d valid %0b data %02h last %0b empty %0b",
                         r.status, r.byte_valid, r.data_byte, r.last_byte,
                         r.empty_message);
    endfunction

    task automatic note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= SHOWN_MISMATCHES)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len    = MAX_LENGTH_RST;
            shift_byte = '0;
            bit_idx    = '0;
            halted     = 1'b0;
            restart_frame();
            expected_results.delete();
            fail_count    = 0;
            pending       = 0;
            bits_seen     = 0;
            bytes_seen    = 0;
            last_seen     = 0;
            empty_seen    = 0;
            too_long_seen = 0;
            halted_seen   = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == ADDR_MAX_LENGTH)
            begin
                if (pwrite)
                    max_len = pwdata;
                else if (prdata !== max_len)
                    note_mismatch($sformatf("max_length read %h, expected %h",
                                            prdata, max_len));
            end

            if (in_valid && in_ready)
            begin
                want = deframe_bit(bit_value);
                expected_results.push_back(want);
                bits_seen++;
                bytes_seen    += want.byte_valid;
                last_seen     += want.last_byte;
                empty_seen    += want.empty_message;
                too_long_seen += (want.status == STATUS_TOO_LONG);
                halted_seen   += (want.status == STATUS_HALTED);
            end

            if (out_valid && out_ready)
            begin
                got.status        = status_t'(status);
                got.byte_valid    = byte_valid;
                got.data_byte     = data_byte;
                got.last_byte     = last_byte;
                got.empty_message = empty_message;
                if (expected_results.size() == 0)
                    note_mismatch({"unexpected result: ", fmt_result(got)});
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        note_mismatch({"expected ", fmt_result(want),
                                       " / got ", fmt_result(got)});
                end
            end

            pending = expected_results.size();
        end
    end

endmodule

### tb/serial_length_prefixed_deframer_core_tb.sv
`timescale 1ns / 1ps

module serial_length_prefixed_deframer_core_tb;

    import slpd_pkg::*;

    // Long receiver hold-off, well below the stall limit
    localparam int HOLD_CYCLES = 300;
    // Cycles without any transfer or APB access before the run is called dead
    localparam int STALL_LIMIT = 2000;
    // Settling time after the last result
    localparam int END_CYCLES  = 8;
    // Bit budget of each random phase
    localparam int RANDOM_BITS = 64;

    localparam logic [ADDR_W-1:0]    ADDR_MAX_LENGTH = {REG_MAX_LENGTH, 2'b00};
    // First index past the register map; writes there must be ignored
    localparam logic [REG_IDX_W-1:0] REG_UNUSED      = REG_MAX_LENGTH + 1'b1;
    localparam logic [ADDR_W-1:0]    ADDR_UNUSED     = {REG_UNUSED, 2'b00};

    logic               clk = 1'b0;
    logic               rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [CFG_W-1:0]   pwdata;
    logic [CFG_W-1:0]   prdata;
    logic               pready;

    logic               in_valid;
    logic               in_ready;
    logic               bit_value;

    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic               byte_valid;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic               empty_message;

    int                 fail_count;
    int                 pending;
    int                 bits_seen;
    int                 bytes_seen;
    int                 last_seen;
    int                 empty_seen;
    int                 too_long_seen;
    int                 halted_seen;

    // Idle percentages for sender and receiver, changed per phase
    int                 tx_idle_pct  = 29;
    int                 rx_idle_pct  = 49;
    // Set by the stimulus, cleared by the receiver once it starts holding off
    bit                 hold_request = 1'b0;
    int                 bits_sent    = 0;
    int                 cfg_writes   = 0;
    int                 quiet_cycles = 0;
    // Stimulus-side copy of max_length, keeps random lengths legal
    logic [CFG_W-1:0]   cfg_max      = MAX_LENGTH_RST;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    serial_length_prefixed_deframer_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .bit_value     (bit_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .byte_valid    (byte_valid),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .empty_message (empty_message)
    );

    // Predicts every result from the transfers it sees and compares in order
    slpd_frame_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .bit_value     (bit_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .byte_valid    (byte_valid),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .empty_message (empty_message),
        .fail_count    (fail_count),
        .pending       (pending),
        .bits_seen     (bits_seen),
        .bytes_seen    (bytes_seen),
        .last_seen     (last_seen),
        .empty_seen    (empty_seen),
        .too_long_seen (too_long_seen),
        .halted_seen   (halted_seen)
    );

    // Receiver: random back-pressure, plus one long hold-off on request so the
    // output register fills and in_ready drops while the sender keeps offering.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: any transfer or APB access restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no transfer in %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One serial bit transfer. Called right after a rising edge; in_ready is
    // looked at on the falling edge, where it has settled for the coming edge.
    task automatic send_bit(input logic b);
        logic taken;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        bit_value <= b;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        bits_sent++;
    endtask

    // LSB first on the wire
    task automatic send_byte(input logic [7:0] b);
        for (int i = 0; i < 8; i++)
            send_bit(b[i]);
    endtask

    // Little-endian length header
    task automatic send_header(input logic [LENGTH_W-1:0] len);
        for (int k = 0; k < LENGTH_BYTES; k++)
            send_byte(len[8*k +: 8]);
    endtask

    task automatic send_payload(input int count);
        repeat (count) send_byte(8'($urandom));
    endtask

    // Stop offering and let every outstanding result come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    // Leaves the bus idle after releasing it, so a following access starts
    // in a fresh cycle
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // The checker compares prdata in the access cycle
    task automatic apb_read(input logic [ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_max_length(input logic [CFG_W-1:0] value);
        apb_write(ADDR_MAX_LENGTH, value);
        apb_read(ADDR_MAX_LENGTH);
        cfg_max = value;
        cfg_writes++;
    endtask

    // Well-formed messages with random content: mostly short, some empty,
    // some longer; lengths clipped to max_length so the block never halts.
    task automatic send_random_messages(input int bit_budget);
        int stop_at;
        int len;
        stop_at = bits_sent + bit_budget;
        while (bits_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(8, 24);
                default: len = $urandom_range(1, 4);
            endcase
            if (len > cfg_max)
                len = int'(cfg_max);
            send_header(LENGTH_W'(len));
            send_payload(len);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        bit_value = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of max_length
        apb_read(ADDR_MAX_LENGTH);

        // ---- directed: sender idles 29%, receiver 49% ----
        // length equal to max_length is still accepted; all-ones, all-zeros
        // and mixed data
        set_max_length(32'd3);
        send_header(LENGTH_W'(3));
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);

        // max_length of zero: a zero-length header still ends the message
        wait_drained();
        set_max_length('0);
        send_header('0);

        // register lowered in the middle of a message, down to the length
        wait_drained();
        set_max_length(32'd5);
        send_header(LENGTH_W'(4));
        send_payload(2);
        wait_drained();
        set_max_length(32'd4);
        send_payload(2);

        // write outside the register map must leave max_length alone
        wait_drained();
        apb_write(ADDR_UNUSED, '0);
        apb_read(ADDR_MAX_LENGTH);

        // ---- random, phase 1: small limit so the boundary gets hit ----
        wait_drained();
        set_max_length($urandom_range(16, 4));
        send_random_messages(RANDOM_BITS);

        // ---- random, phase 2: idling swapped, limit all ones ----
        wait_drained();
        tx_idle_pct = 49;
        rx_idle_pct = 29;
        set_max_length('1);
        send_random_messages(RANDOM_BITS);

        // ---- random, phase 3: no idling, one long receiver hold-off ----
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_max_length($urandom_range(32'hFFFF_FFFE, 24));
        hold_request = 1'b1;
        send_random_messages(RANDOM_BITS);

        // ---- too long, then halted until reset; must come last ----
        wait_drained();
        set_max_length('1);
        send_header(LENGTH_W'(32'hFFFF_FFFF));
        send_payload(1);
        wait_drained();
        set_max_length('0);
        // first byte is rejected, every later bit answers halted
        send_payload(2);

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        $display("covered %0d bits: %0d payload bytes, %0d message ends, %0d empty headers",
                 bits_seen, bytes_seen, last_seen, empty_seen);
        $display("%0d max_length writes (zero and all ones among them), %0d too-long, %0d halted",
                 cfg_writes, too_long_seen, halted_seen);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/slpd_pkg.sv
rtl/slpd_bit_gather.sv
rtl/slpd_frame_ctrl.sv
rtl/serial_length_prefixed_deframer_core.sv
tb/slpd_frame_checker.sv
tb/serial_length_prefixed_deframer_core_tb.sv
